FILE: rtl/bcl_pkg.sv
// bcl_pkg: shared types and constants for the button click / long press classifier
// no dependencies; used by the interfaces and every rtl module
`timescale 1ns / 1ps

package bcl_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD  = 3'd4;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] MIN_PRESS_RST  = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [CFG_W-1:0] MERGE_RST      = 16'd300;
    localparam logic [CFG_W-1:0] RESET_HOLD_RST = 16'd3000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] min_press_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] merge_ms;
        logic [CFG_W-1:0] reset_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              button_down;
        logic              reset_down;
    } t_poll;

    typedef struct packed {
        logic click;
        logic long_press;
        logic restart;
        logic halted;
    } t_result;

endpackage

FILE: rtl/bcl_if.sv
// bcl_if: valid/ready channel interfaces for polls, results and register writes
// depends on bcl_pkg
`timescale 1ns / 1ps

interface bcl_poll_if;
    logic                      valid;
    logic                      ready;
    logic [bcl_pkg::TIME_W-1:0] now_ms;
    logic                      button_down;
    logic                      reset_down;

    modport source (output valid, output now_ms, output button_down, output reset_down,
                    input ready);
    modport sink   (input valid, input now_ms, input button_down, input reset_down,
                    output ready);
endinterface

interface bcl_result_if;
    logic valid;
    logic ready;
    logic click;
    logic long_press;
    logic restart;
    logic halted;

    modport source (output valid, output click, output long_press, output restart,
                    output halted, input ready);
    modport sink   (input valid, input click, input long_press, input restart,
                    input halted, output ready);
endinterface

interface bcl_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bcl_pkg::CFG_IDX_W-1:0] index;
    logic [bcl_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/bcl_cfg.sv
// bcl_cfg: configuration register file, one 16-bit register per timing threshold
// depends on bcl_pkg
`timescale 1ns / 1ps

module bcl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [bcl_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [bcl_pkg::CFG_W-1:0]     i_wr_data,
    output bcl_pkg::t_cfg                 o_cfg
);

    bcl_pkg::t_cfg r_cfg;
    bcl_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (i_wr_index)
                bcl_pkg::REG_DEBOUNCE:   n_cfg.debounce_ms   = i_wr_data;
                bcl_pkg::REG_MIN_PRESS:  n_cfg.min_press_ms  = i_wr_data;
                bcl_pkg::REG_LONG_PRESS: n_cfg.long_press_ms = i_wr_data;
                bcl_pkg::REG_MERGE:      n_cfg.merge_ms      = i_wr_data;
                bcl_pkg::REG_RESET_HOLD: n_cfg.reset_hold_ms = i_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bcl_pkg::DEBOUNCE_RST;
            r_cfg.min_press_ms  <= bcl_pkg::MIN_PRESS_RST;
            r_cfg.long_press_ms <= bcl_pkg::LONG_PRESS_RST;
            r_cfg.merge_ms      <= bcl_pkg::MERGE_RST;
            r_cfg.reset_hold_ms <= bcl_pkg::RESET_HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/bcl_core.sv
// bcl_core: poll input register, classifier state update and result register
// depends on bcl_pkg
`timescale 1ns / 1ps

module bcl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcl_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bcl_pkg::t_poll     i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bcl_pkg::t_result   o_out_word
);

    localparam int TW = bcl_pkg::TIME_W;

    // input stage
    logic            r_in_valid;
    bcl_pkg::t_poll  r_in_word;

    // result stage
    logic             r_out_valid;
    bcl_pkg::t_result r_out_word;
    bcl_pkg::t_result n_out_word;

    // classifier state
    logic          r_last_raw,     n_last_raw;
    logic [TW-1:0] r_quiet_since,  n_quiet_since;
    logic          r_press_active, n_press_active;
    logic [TW-1:0] r_press_start,  n_press_start;
    logic          r_click_pending, n_click_pending;
    logic [TW-1:0] r_pending_since, n_pending_since;
    logic          r_reset_active, n_reset_active;
    logic [TW-1:0] r_reset_start,  n_reset_start;
    logic          r_shutdown,     n_shutdown;

    logic          w_adv;
    logic          w_fire;
    logic [TW-1:0] w_now;
    logic          w_down;
    logic          w_rdown;
    logic [TW-1:0] w_reset_el;
    logic [TW-1:0] w_quiet_el;
    logic [TW-1:0] w_press_el;
    logic [TW-1:0] w_pend_el;
    logic          w_restart;
    logic          w_stable;
    logic          w_pend_set;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_now   = r_in_word.now_ms;
    assign w_down  = r_in_word.button_down;
    assign w_rdown = r_in_word.reset_down;

    // wrapping elapsed times
    assign w_reset_el = w_now - r_reset_start;
    assign w_quiet_el = w_now - r_quiet_since;
    assign w_press_el = w_now - r_press_start;
    assign w_pend_el  = w_now - r_pending_since;

    always_comb begin
        n_last_raw      = r_last_raw;
        n_quiet_since   = r_quiet_since;
        n_press_active  = r_press_active;
        n_press_start   = r_press_start;
        n_click_pending = r_click_pending;
        n_pending_since = r_pending_since;
        n_reset_active  = r_reset_active;
        n_reset_start   = r_reset_start;
        n_shutdown      = r_shutdown;
        n_out_word      = '0;
        w_restart       = 1'b0;
        w_stable        = 1'b0;
        w_pend_set      = 1'b0;

        if (r_shutdown) begin
            n_out_word.halted = 1'b1;
        end else begin
            priority if (w_rdown && !r_reset_active) begin
                n_reset_active = 1'b1;
                n_reset_start  = w_now;
            end else if (!w_rdown) begin
                n_reset_active = 1'b0;
            end else if (w_reset_el > {{(TW-bcl_pkg::CFG_W){1'b0}}, i_cfg.reset_hold_ms}) begin
                w_restart = 1'b1;
            end else begin
            end

            if (!w_restart) begin
                // raw change restarts quiet timer and can never pass the strict compare
                if (w_down != r_last_raw) begin
                    n_quiet_since = w_now;
                end else begin
                    w_stable = w_quiet_el > {{(TW-bcl_pkg::CFG_W){1'b0}}, i_cfg.debounce_ms};
                end

                if (w_stable) begin
                    priority if (w_down && !r_press_active) begin
                        n_press_active = 1'b1;
                        n_press_start  = w_now;
                    end else if (!w_down && r_press_active) begin
                        if (w_press_el >= {{(TW-bcl_pkg::CFG_W){1'b0}}, i_cfg.min_press_ms}) begin
                            n_click_pending = 1'b1;
                            n_pending_since = w_now;
                            w_pend_set      = 1'b1;
                        end
                        n_press_active = 1'b0;
                    end else if (w_down && r_press_active) begin
                        if (w_press_el >= {{(TW-bcl_pkg::CFG_W){1'b0}},
                                           i_cfg.long_press_ms}) begin
                            n_click_pending       = 1'b0;
                            n_pending_since       = '0;
                            n_shutdown            = 1'b1;
                            n_press_active        = 1'b0;
                            n_out_word.long_press = 1'b1;
                        end
                    end else begin
                    end
                end

                // a click set on this poll has zero elapsed time
                if (n_click_pending &&
                    (w_pend_set ? (i_cfg.merge_ms == '0)
                                : (w_pend_el >= {{(TW-bcl_pkg::CFG_W){1'b0}},
                                                 i_cfg.merge_ms}))) begin
                    n_out_word.click = 1'b1;
                    n_click_pending  = 1'b0;
                    n_pending_since  = '0;
                end

                n_last_raw = w_down;
            end

            n_out_word.restart = w_restart;
            n_out_word.halted  = n_shutdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_last_raw      <= 1'b0;
            r_quiet_since   <= '0;
            r_press_active  <= 1'b0;
            r_press_start   <= '0;
            r_click_pending <= 1'b0;
            r_pending_since <= '0;
            r_reset_active  <= 1'b0;
            r_reset_start   <= '0;
            r_shutdown      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (w_fire) begin
                r_last_raw      <= n_last_raw;
                r_quiet_since   <= n_quiet_since;
                r_press_active  <= n_press_active;
                r_press_start   <= n_press_start;
                r_click_pending <= n_click_pending;
                r_pending_since <= n_pending_since;
                r_reset_active  <= n_reset_active;
                r_reset_start   <= n_reset_start;
                r_shutdown      <= n_shutdown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_fire) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

FILE: rtl/button_click_long_press_classifier.sv
// button_click_long_press_classifier: top level, channel wiring of config and core
// depends on bcl_pkg, bcl_if, bcl_cfg, bcl_core
//
// usage:
//   i_poll    one word per poll: now_ms timestamp, raw button_down and reset_down
//   o_result  one word per poll: click, long_press, restart, halted
//   i_cfg     register writes, index 0..4 = debounce, min press, long press,
//             merge, reset hold; other indexes are dropped; always ready
//   path: an accepted poll is held in the input register, and its result word
//            is written to the result register once that register can advance
//   throughput: one poll per cycle while o_result is not stalled, set by the
//            combinational state update between the input and result registers
//   stall: when o_result is not taken the result holds, the input register
//          fills and then i_poll.ready drops; nothing is lost or repeated
//   reset: synchronous active-low i_rst_n clears both stages, all button
//          state and the shutdown latch, and reloads the register defaults
//   once a long press latches shutdown, every later poll reports halted only
`timescale 1ns / 1ps

module button_click_long_press_classifier (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bcl_poll_if.sink        i_poll,
    bcl_result_if.source    o_result,
    bcl_cfg_if.sink         i_cfg
);

    bcl_pkg::t_cfg    w_cfg;
    bcl_pkg::t_poll   w_in_word;
    bcl_pkg::t_result w_out_word;
    logic             w_in_ready;
    logic             w_out_valid;

    assign i_cfg.ready = 1'b1;

    bcl_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (w_cfg)
    );

    assign w_in_word.now_ms      = i_poll.now_ms;
    assign w_in_word.button_down = i_poll.button_down;
    assign w_in_word.reset_down  = i_poll.reset_down;

    bcl_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_poll.valid),
        .o_in_ready  (w_in_ready),
        .i_in_word   (w_in_word),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_out_word  (w_out_word)
    );

    assign i_poll.ready        = w_in_ready;
    assign o_result.valid      = w_out_valid;
    assign o_result.click      = w_out_word.click;
    assign o_result.long_press = w_out_word.long_press;
    assign o_result.restart    = w_out_word.restart;
    assign o_result.halted     = w_out_word.halted;

endmodule
